// File: hw/rtl/bba_pkg.sv
// Shared types for the drawing bounding box accumulator.
package bba_pkg;

  // Primitive kinds as they arrive on req_type.
  typedef enum logic [1:0] {
    KIND_LINE   = 2'd0,
    KIND_CIRCLE = 2'd1,
    KIND_POINT  = 2'd2,
    KIND_ARC    = 2'd3
  } kind_t;

  // Control half of a classified command, handed from the front end to the back end.
  typedef struct packed {
    kind_t kind;
    logic  restart;
    logic  start_at_center;
    logic  end_at_center;
  } cmd_ctrl_t;

endpackage

// File: hw/rtl/bba_front.sv
// Front end: accepts input beats, classifies them and queues commands for the back end.
module bba_front #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   req_type,
  input  logic                         restart,
  input  logic signed [COORD_BITS-1:0] p0x,
  input  logic signed [COORD_BITS-1:0] p0y,
  input  logic signed [COORD_BITS-1:0] p1x,
  input  logic signed [COORD_BITS-1:0] p1y,
  input  logic signed [COORD_BITS-1:0] p2x,
  input  logic signed [COORD_BITS-1:0] p2y,
  input  logic signed [COORD_BITS-1:0] radius,
  output logic                         cmd_valid,
  input  logic                         cmd_take,
  output bba_pkg::cmd_ctrl_t           cmd_ctrl,
  output logic signed [COORD_BITS-1:0] cmd_cx,
  output logic signed [COORD_BITS-1:0] cmd_cy,
  output logic signed [COORD_BITS-1:0] cmd_ax,
  output logic signed [COORD_BITS-1:0] cmd_ay,
  output logic signed [COORD_BITS-1:0] cmd_bx,
  output logic signed [COORD_BITS-1:0] cmd_by,
  output logic signed [COORD_BITS-1:0] cmd_rad
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  bba_pkg::cmd_ctrl_t           ctrl_q [DEPTH];
  logic signed [COORD_BITS-1:0] cx_q   [DEPTH];
  logic signed [COORD_BITS-1:0] cy_q   [DEPTH];
  logic signed [COORD_BITS-1:0] ax_q   [DEPTH];
  logic signed [COORD_BITS-1:0] ay_q   [DEPTH];
  logic signed [COORD_BITS-1:0] bx_q   [DEPTH];
  logic signed [COORD_BITS-1:0] by_q   [DEPTH];
  logic signed [COORD_BITS-1:0] rad_q  [DEPTH];

  logic [PW-1:0]      wr_ptr;
  logic [PW-1:0]      rd_ptr;
  logic [CW-1:0]      count;
  logic               push_ok;
  logic               pop_ok;
  bba_pkg::cmd_ctrl_t in_ctrl;

  assign full      = (count == DEPTH_C);
  assign cmd_valid = (count != '0);
  assign push_ok   = push && !full;
  assign pop_ok    = cmd_take && cmd_valid;

  // Classify the beat: kind, restart, and whether the arc points sit on the center.
  always_comb begin
    in_ctrl.kind            = bba_pkg::kind_t'(req_type);
    in_ctrl.restart         = restart;
    in_ctrl.start_at_center = (p1x == p0x) && (p1y == p0y);
    in_ctrl.end_at_center   = (p2x == p0x) && (p2y == p0y);
  end

  // Command queue storage.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      ctrl_q[wr_ptr] <= in_ctrl;
      cx_q[wr_ptr]   <= p0x;
      cy_q[wr_ptr]   <= p0y;
      ax_q[wr_ptr]   <= p1x;
      ay_q[wr_ptr]   <= p1y;
      bx_q[wr_ptr]   <= p2x;
      by_q[wr_ptr]   <= p2y;
      rad_q[wr_ptr]  <= radius;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push_ok && !pop_ok) begin
        count <= count + CW'(1);
      end else if (pop_ok && !push_ok) begin
        count <= count - CW'(1);
      end
    end
  end

  assign cmd_ctrl = ctrl_q[rd_ptr];
  assign cmd_cx   = cx_q[rd_ptr];
  assign cmd_cy   = cy_q[rd_ptr];
  assign cmd_ax   = ax_q[rd_ptr];
  assign cmd_ay   = ay_q[rd_ptr];
  assign cmd_bx   = bx_q[rd_ptr];
  assign cmd_by   = by_q[rd_ptr];
  assign cmd_rad  = rad_q[rd_ptr];

endmodule

// File: hw/rtl/bba_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module bba_sqrt #(
  parameter int ROOT_BITS = 25
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [2*ROOT_BITS-1:0]   radicand,
  output logic                     done,
  output logic [ROOT_BITS-1:0]     root
);

  localparam int RW = ROOT_BITS + 2;
  localparam int CW = $clog2(ROOT_BITS + 1);
  localparam logic [CW-1:0] LAST = CW'(ROOT_BITS - 1);

  logic [2*ROOT_BITS-1:0] rad_sh;
  logic [RW-1:0]          rem;
  logic [RW-1:0]          rem_sh;
  logic [RW-1:0]          trial;
  logic [CW-1:0]          cnt;
  logic                   busy;

  // Bring down the next two radicand bits and form the trial subtrahend.
  assign rem_sh = {rem[RW-3:0], rad_sh[2*ROOT_BITS-1 -: 2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    // Datapath: restoring root digit step.
    if (start) begin
      rad_sh <= radicand;
      rem    <= '0;
      root   <= '0;
    end else if (busy) begin
      rad_sh <= rad_sh << 2;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_BITS-2:0], 1'b0};
      end
    end
    // Control: step counter and completion pulse.
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hw/rtl/bba_back.sv
// Back end: executes queued commands, holds the running box and the result register.
module bba_back #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_take,
  input  bba_pkg::cmd_ctrl_t           cmd_ctrl,
  input  logic signed [COORD_BITS-1:0] cmd_cx,
  input  logic signed [COORD_BITS-1:0] cmd_cy,
  input  logic signed [COORD_BITS-1:0] cmd_ax,
  input  logic signed [COORD_BITS-1:0] cmd_ay,
  input  logic signed [COORD_BITS-1:0] cmd_bx,
  input  logic signed [COORD_BITS-1:0] cmd_by,
  input  logic signed [COORD_BITS-1:0] cmd_rad,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COORD_BITS-1:0] box_min_x,
  output logic signed [COORD_BITS-1:0] box_max_x,
  output logic signed [COORD_BITS-1:0] box_min_y,
  output logic signed [COORD_BITS-1:0] box_max_y,
  output logic                         bad_arc
);

  localparam int CB = COORD_BITS;
  localparam bit CAN_OVER = (2 * CB + 1 > 64);
  localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};

  // Quadrants, counted counter-clockwise from the positive x axis.
  localparam logic [1:0] Q_FIRST  = 2'd0;
  localparam logic [1:0] Q_SECOND = 2'd1;
  localparam logic [1:0] Q_THIRD  = 2'd2;
  localparam logic [1:0] Q_FOURTH = 2'd3;

  // Extreme mask bits; extreme i is passed when the walk leaves quadrant i.
  localparam int X_NORTH = 0;
  localparam int X_WEST  = 1;
  localparam int X_SOUTH = 2;
  localparam int X_EAST  = 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LAUNCH,
    S_ROOT,
    S_EXT,
    S_COMMIT
  } state_t;

  state_t             state;
  bba_pkg::cmd_ctrl_t ctrl;
  logic signed [CB-1:0] cx, cy, ax, ay, bx, by;
  logic signed [CB:0]   dx0, dy0, dx1, dy1;
  logic [1:0]           step;
  logic [2*CB-1:0]      sqx, sqy;
  logic signed [2*CB:0] pa, pb;
  logic [CB:0]          r;
  logic signed [CB-1:0] ext_n, ext_s, ext_e, ext_w;
  logic [3:0]           mask;
  logic signed [CB-1:0] min_x, max_x, min_y, max_y;
  logic                 res_valid;

  // Combinational helpers.
  logic signed [CB:0]     ma, mb;
  logic signed [2*CB+1:0] prod;
  logic [2*CB:0]          sum;
  logic                   over;
  logic                   sqrt_start;
  logic                   sqrt_done;
  logic [CB:0]            sqrt_root;
  logic signed [CB:0]     rad_ext;
  logic [CB:0]            rad_abs;
  logic signed [CB+1:0]   cx_w, cy_w, r_w;
  logic [1:0]             quad_j, quad_k, span;
  logic [3:0]             mask_next;
  logic                   arc_bad, arc_full;
  logic                   use_c, use_a, use_b;
  logic signed [CB-1:0]   min_x_next, max_x_next, min_y_next, max_y_next;
  logic                   commit_go;

  function automatic logic signed [CB-1:0] sat_c(input logic signed [CB+1:0] v);
    logic fits;
    fits = (v[CB+1:CB-1] == 3'b000) || (v[CB+1:CB-1] == 3'b111);
    if (fits) begin
      return v[CB-1:0];
    end else if (v[CB+1]) begin
      return C_MIN;
    end else begin
      return C_MAX;
    end
  endfunction

  function automatic logic [1:0] quad_of(input logic signed [CB:0] x,
                                         input logic signed [CB:0] y);
    logic xneg, yneg, xzero, yzero;
    xneg  = x[CB];
    yneg  = y[CB];
    xzero = (x == '0);
    yzero = (y == '0);
    if (!xneg && !yneg && !yzero) begin
      return Q_FIRST;
    end else if (xneg && !yneg) begin
      return Q_SECOND;
    end else if ((xneg || xzero) && yneg) begin
      return Q_THIRD;
    end else begin
      return Q_FOURTH;
    end
  endfunction

  function automatic logic signed [CB-1:0] smin(input logic signed [CB-1:0] a,
                                                input logic signed [CB-1:0] b);
    return (b < a) ? b : a;
  endfunction

  function automatic logic signed [CB-1:0] smax(input logic signed [CB-1:0] a,
                                                input logic signed [CB-1:0] b);
    return (b > a) ? b : a;
  endfunction

  assign cmd_take   = (state == S_IDLE) && cmd_valid;
  assign empty      = !res_valid;
  assign commit_go  = (state == S_COMMIT) && (!res_valid || pop);

  // Circle radius magnitude.
  assign rad_ext = {cmd_rad[CB-1], cmd_rad};
  assign rad_abs = rad_ext[CB] ? (CB+1)'(-rad_ext) : rad_ext;

  // Shared multiplier: squares of the start offset, then the two terms of the cross product.
  always_comb begin
    case (step)
      2'd0: begin
        ma = dx0;
        mb = dx0;
      end
      2'd1: begin
        ma = dy0;
        mb = dy0;
      end
      2'd2: begin
        ma = dy1;
        mb = dx0;
      end
      default: begin
        ma = dx1;
        mb = dy0;
      end
    endcase
    prod = ma * mb;
  end

  // Squared radius, and the case where it carries into bit 2*CB (checked only when the sum is wider than 64 bits).
  assign sum        = {1'b0, sqx} + {1'b0, sqy};
  assign over       = CAN_OVER && sum[2*CB];
  assign sqrt_start = (state == S_LAUNCH) && !over;

  bba_sqrt #(
    .ROOT_BITS (CB + 1)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand ({1'b0, sum}),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // Extreme points and the quadrant walk.
  assign cx_w   = {{2{cx[CB-1]}}, cx};
  assign cy_w   = {{2{cy[CB-1]}}, cy};
  assign r_w    = {1'b0, r};
  assign quad_j = quad_of(dx0, dy0);
  assign quad_k = quad_of(dx1, dy1);
  assign span   = quad_k - quad_j;

  always_comb begin
    mask_next = '0;
    if (ctrl.kind == bba_pkg::KIND_CIRCLE) begin
      mask_next = 4'b1111;
    end else if (ctrl.kind == bba_pkg::KIND_ARC && !ctrl.start_at_center &&
                 !ctrl.end_at_center) begin
      if (quad_j == quad_k && pa < pb) begin
        mask_next = 4'b1111;
      end else begin
        for (int i = 0; i < 4; i++) begin
          mask_next[i] = 2'(2'(i) - quad_j) < span;
        end
      end
    end
  end

  // Which points enter the box for this command.
  assign arc_bad  = (ctrl.kind == bba_pkg::KIND_ARC) && !ctrl.start_at_center &&
                    ctrl.end_at_center;
  assign arc_full = (ctrl.kind == bba_pkg::KIND_ARC) && !arc_bad;
  assign use_c    = (ctrl.kind == bba_pkg::KIND_LINE) || (ctrl.kind == bba_pkg::KIND_POINT);
  assign use_a    = (ctrl.kind == bba_pkg::KIND_LINE) || arc_full;
  assign use_b    = arc_full;

  // Widen the box over the selected points.
  always_comb begin
    if (ctrl.restart) begin
      min_x_next = C_MAX;
      max_x_next = C_MIN;
      min_y_next = C_MAX;
      max_y_next = C_MIN;
    end else begin
      min_x_next = min_x;
      max_x_next = max_x;
      min_y_next = min_y;
      max_y_next = max_y;
    end
    if (use_c) begin
      min_x_next = smin(min_x_next, cx);
      max_x_next = smax(max_x_next, cx);
      min_y_next = smin(min_y_next, cy);
      max_y_next = smax(max_y_next, cy);
    end
    if (use_a) begin
      min_x_next = smin(min_x_next, ax);
      max_x_next = smax(max_x_next, ax);
      min_y_next = smin(min_y_next, ay);
      max_y_next = smax(max_y_next, ay);
    end
    if (use_b) begin
      min_x_next = smin(min_x_next, bx);
      max_x_next = smax(max_x_next, bx);
      min_y_next = smin(min_y_next, by);
      max_y_next = smax(max_y_next, by);
    end
    if (mask[X_NORTH]) begin
      min_x_next = smin(min_x_next, cx);
      max_x_next = smax(max_x_next, cx);
      max_y_next = smax(max_y_next, ext_n);
    end
    if (mask[X_WEST]) begin
      min_x_next = smin(min_x_next, ext_w);
      min_y_next = smin(min_y_next, cy);
      max_y_next = smax(max_y_next, cy);
    end
    if (mask[X_SOUTH]) begin
      min_x_next = smin(min_x_next, cx);
      max_x_next = smax(max_x_next, cx);
      min_y_next = smin(min_y_next, ext_s);
    end
    if (mask[X_EAST]) begin
      max_x_next = smax(max_x_next, ext_e);
      min_y_next = smin(min_y_next, cy);
      max_y_next = smax(max_y_next, cy);
    end
  end

  // Sequencer, working registers, box state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      min_x     <= C_MAX;
      max_x     <= C_MIN;
      min_y     <= C_MAX;
      max_y     <= C_MIN;
    end else begin
      if (pop && res_valid && !commit_go) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            ctrl <= cmd_ctrl;
            cx   <= cmd_cx;
            cy   <= cmd_cy;
            ax   <= cmd_ax;
            ay   <= cmd_ay;
            bx   <= cmd_bx;
            by   <= cmd_by;
            dx0  <= {cmd_ax[CB-1], cmd_ax} - {cmd_cx[CB-1], cmd_cx};
            dy0  <= {cmd_ay[CB-1], cmd_ay} - {cmd_cy[CB-1], cmd_cy};
            dx1  <= {cmd_bx[CB-1], cmd_bx} - {cmd_cx[CB-1], cmd_cx};
            dy1  <= {cmd_by[CB-1], cmd_by} - {cmd_cy[CB-1], cmd_cy};
            r    <= rad_abs;
            step <= 2'd0;
            if (cmd_ctrl.kind == bba_pkg::KIND_ARC && !cmd_ctrl.start_at_center &&
                !cmd_ctrl.end_at_center) begin
              state <= S_MUL;
            end else begin
              state <= S_EXT;
            end
          end
        end
        S_MUL: begin
          case (step)
            2'd0: sqx <= prod[2*CB-1:0];
            2'd1: sqy <= prod[2*CB-1:0];
            2'd2: pa  <= prod[2*CB:0];
            default: pb <= prod[2*CB:0];
          endcase
          step <= step + 2'd1;
          if (step == 2'd3) begin
            state <= S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          if (over) begin
            r     <= (CB+1)'(1) << CB;
            state <= S_EXT;
          end else begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (sqrt_done) begin
            r     <= sqrt_root;
            state <= S_EXT;
          end
        end
        S_EXT: begin
          ext_n <= sat_c(cy_w + r_w);
          ext_s <= sat_c(cy_w - r_w);
          ext_e <= sat_c(cx_w + r_w);
          ext_w <= sat_c(cx_w - r_w);
          mask  <= mask_next;
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (commit_go) begin
            min_x     <= min_x_next;
            max_x     <= max_x_next;
            min_y     <= min_y_next;
            max_y     <= max_y_next;
            box_min_x <= min_x_next;
            box_max_x <= max_x_next;
            box_min_y <= min_y_next;
            box_max_y <= max_y_next;
            bad_arc   <= arc_bad;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/drawing_bounding_box_accumulator_core.sv
// Top level of the drawing bounding box accumulator: front end, command queue and back end.
// Lines, circles, points and arcs with start or end on the centre go from accept to the
// extreme and commit states; other arcs first pass the multiply, launch and root states
// (one root bit per cycle), skipping the root on squared-radius overflow. One beat runs at a time.
// The two-entry command queue accepts beats while the back end works or a result waits.
// Synchronous reset empties the queue and the result register and sets the box to empty.
module drawing_bounding_box_accumulator_core #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   req_type,
  input  logic                         restart,
  input  logic signed [COORD_BITS-1:0] p0x,
  input  logic signed [COORD_BITS-1:0] p0y,
  input  logic signed [COORD_BITS-1:0] p1x,
  input  logic signed [COORD_BITS-1:0] p1y,
  input  logic signed [COORD_BITS-1:0] p2x,
  input  logic signed [COORD_BITS-1:0] p2y,
  input  logic signed [COORD_BITS-1:0] radius,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COORD_BITS-1:0] box_min_x,
  output logic signed [COORD_BITS-1:0] box_max_x,
  output logic signed [COORD_BITS-1:0] box_min_y,
  output logic signed [COORD_BITS-1:0] box_max_y,
  output logic                         bad_arc
);

  logic                         cmd_valid;
  logic                         cmd_take;
  bba_pkg::cmd_ctrl_t           cmd_ctrl;
  logic signed [COORD_BITS-1:0] cmd_cx, cmd_cy, cmd_ax, cmd_ay, cmd_bx, cmd_by, cmd_rad;

  // Input side: classification and command queue.
  bba_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req_type  (req_type),
    .restart   (restart),
    .p0x       (p0x),
    .p0y       (p0y),
    .p1x       (p1x),
    .p1y       (p1y),
    .p2x       (p2x),
    .p2y       (p2y),
    .radius    (radius),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd_ctrl  (cmd_ctrl),
    .cmd_cx    (cmd_cx),
    .cmd_cy    (cmd_cy),
    .cmd_ax    (cmd_ax),
    .cmd_ay    (cmd_ay),
    .cmd_bx    (cmd_bx),
    .cmd_by    (cmd_by),
    .cmd_rad   (cmd_rad)
  );

  // Execution side: arc geometry, box update and result register.
  bba_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd_ctrl  (cmd_ctrl),
    .cmd_cx    (cmd_cx),
    .cmd_cy    (cmd_cy),
    .cmd_ax    (cmd_ax),
    .cmd_ay    (cmd_ay),
    .cmd_bx    (cmd_bx),
    .cmd_by    (cmd_by),
    .cmd_rad   (cmd_rad),
    .empty     (empty),
    .pop       (pop),
    .box_min_x (box_min_x),
    .box_max_x (box_max_x),
    .box_min_y (box_min_y),
    .box_max_y (box_max_y),
    .bad_arc   (bad_arc)
  );

endmodule
